// ===== hw/rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and fixed field widths for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int BASE_WIDTH  = 63;
    localparam int EXPIN_WIDTH = 63;
    localparam int CFG_WIDTH   = 32;
    localparam int OUT_WIDTH   = 32;

    localparam logic [CFG_WIDTH-1:0] MODULUS_RESET = 32'd1000000007;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_LAUNCH,
        S_WAIT,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply, base^exponent mod modulus, one word at a time.
// The base is first reduced modulo the modulus; then, per exponent bit, a squaring
// and a multiply run in parallel, the product kept when the bit is set. A zero
// exponent or a zero result goes straight to the strobe. Busy holds until the
// strobe cycle ends and the receiver cannot stall.
// Synchronous active-low reset; modulus resets to 1000000007.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 63
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mexp_pkg::CFG_WIDTH-1:0]   i_cfg_wdata,
    input  logic                             start,
    output logic                             busy,
    input  logic [mexp_pkg::BASE_WIDTH-1:0]  i_base_value,
    input  logic [mexp_pkg::EXPIN_WIDTH-1:0] i_exponent,
    output logic                             o_valid,
    output logic [mexp_pkg::OUT_WIDTH-1:0]   o_power_result
);

    mexp_pkg::t_state r_state, n_state;

    logic [mexp_pkg::CFG_WIDTH-1:0] r_modulus;
    logic [EXP_WIDTH-1:0]           r_exp;
    logic [MOD_WIDTH-1:0]           r_sq;
    logic [MOD_WIDTH-1:0]           r_acc;
    logic [MOD_WIDTH-1:0]           w_mod;
    logic                           w_accept;
    logic                           w_red_start;
    logic                           w_mul_start;
    logic                           w_red_done;
    logic [MOD_WIDTH-1:0]           w_red_rem;
    logic                           w_sq_done;
    logic [MOD_WIDTH-1:0]           w_sq_prod;
    logic                           w_ml_done;
    logic [MOD_WIDTH-1:0]           w_ml_prod;
    logic                           w_zero_res;
    logic                           w_exp_last;

    assign w_mod      = r_modulus[MOD_WIDTH-1:0];
    assign w_accept   = start && (r_state == mexp_pkg::S_IDLE);
    assign w_zero_res = (w_mod == '0) || (r_sq == '0);
    assign w_exp_last = ((r_exp >> 1) == '0);

    mexp_modred #(.MOD_WIDTH(MOD_WIDTH)) u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_red_start),
        .i_base  (i_base_value),
        .i_mod   (w_mod),
        .o_done  (w_red_done),
        .o_rem   (w_red_rem)
    );

    mexp_modmul #(.MOD_WIDTH(MOD_WIDTH)) u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_sq),
        .i_b     (r_sq),
        .i_mod   (w_mod),
        .o_done  (w_sq_done),
        .o_prod  (w_sq_prod)
    );

    mexp_modmul #(.MOD_WIDTH(MOD_WIDTH)) u_ml (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_acc),
        .i_b     (r_sq),
        .i_mod   (w_mod),
        .o_done  (w_ml_done),
        .o_prod  (w_ml_prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mexp_pkg::S_IDLE: begin
                if (start) n_state = mexp_pkg::S_REDUCE;
            end
            mexp_pkg::S_REDUCE: begin
                if (w_red_done) n_state = mexp_pkg::S_CHECK;
            end
            mexp_pkg::S_CHECK: begin
                if (w_zero_res || (r_exp == '0)) begin
                    n_state = mexp_pkg::S_DONE;
                end else begin
                    n_state = mexp_pkg::S_LAUNCH;
                end
            end
            mexp_pkg::S_LAUNCH: begin
                n_state = mexp_pkg::S_WAIT;
            end
            mexp_pkg::S_WAIT: begin
                if (w_sq_done) begin
                    n_state = w_exp_last ? mexp_pkg::S_DONE : mexp_pkg::S_LAUNCH;
                end
            end
            mexp_pkg::S_DONE: begin
                n_state = mexp_pkg::S_IDLE;
            end
            default: begin
                n_state = mexp_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        busy        = 1'b1;
        o_valid     = 1'b0;
        w_red_start = 1'b0;
        w_mul_start = 1'b0;
        case (r_state)
            mexp_pkg::S_IDLE: begin
                busy        = 1'b0;
                w_red_start = start;
            end
            mexp_pkg::S_LAUNCH: begin
                w_mul_start = 1'b1;
            end
            mexp_pkg::S_DONE: begin
                o_valid = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mexp_pkg::S_IDLE;
            r_modulus <= mexp_pkg::MODULUS_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_modulus <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_exp <= i_exponent[EXP_WIDTH-1:0];
            r_acc <= MOD_WIDTH'(1);
        end
        if ((r_state == mexp_pkg::S_REDUCE) && w_red_done) begin
            r_sq <= w_red_rem;
        end
        if ((r_state == mexp_pkg::S_CHECK) && w_zero_res) begin
            r_acc <= '0;
        end
        if ((r_state == mexp_pkg::S_WAIT) && w_sq_done) begin
            r_sq  <= w_sq_prod;
            r_exp <= r_exp >> 1;
            if (r_exp[0] && w_ml_done) r_acc <= w_ml_prod;
        end
    end

    assign o_power_result = mexp_pkg::OUT_WIDTH'(r_acc);

endmodule

// ===== hw/rtl/mexp_modred.sv =====
// ----------------------------------------------------------------------------
// mexp_modred
// Bit-serial reduction of the base modulo the modulus, one base bit per cycle
// from the most significant end.
// ----------------------------------------------------------------------------
module mexp_modred #(
    parameter int MOD_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mexp_pkg::BASE_WIDTH-1:0] i_base,
    input  logic [MOD_WIDTH-1:0]           i_mod,
    output logic                           o_done,
    output logic [MOD_WIDTH-1:0]           o_rem
);

    localparam int CNT_W = $clog2(mexp_pkg::BASE_WIDTH + 1);

    logic [mexp_pkg::BASE_WIDTH-1:0] r_shift, n_shift;
    logic [MOD_WIDTH-1:0]            r_rem, n_rem;
    logic [CNT_W-1:0]                r_cnt, n_cnt;
    logic                            r_done, n_done;
    logic [MOD_WIDTH:0]              w_t;
    logic [MOD_WIDTH:0]              w_sub;

    assign w_t   = {r_rem, r_shift[mexp_pkg::BASE_WIDTH-1]};
    assign w_sub = w_t - {1'b0, i_mod};

    always_comb begin
        n_shift = r_shift;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_start) begin
            n_shift = i_base;
            n_rem   = '0;
            n_cnt   = CNT_W'(mexp_pkg::BASE_WIDTH);
        end else if (r_cnt != '0) begin
            n_shift = r_shift << 1;
            n_rem   = (w_t >= {1'b0, i_mod}) ? w_sub[MOD_WIDTH-1:0] : w_t[MOD_WIDTH-1:0];
            n_cnt   = r_cnt - CNT_W'(1);
            n_done  = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_shift <= n_shift;
        r_rem   <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/mexp_modmul.sv =====
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle,
// shift-add with a conditional subtract of m or 2m. Operands below m.
// ----------------------------------------------------------------------------
module mexp_modmul #(
    parameter int MOD_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MOD_WIDTH-1:0] i_a,
    input  logic [MOD_WIDTH-1:0] i_b,
    input  logic [MOD_WIDTH-1:0] i_mod,
    output logic                 o_done,
    output logic [MOD_WIDTH-1:0] o_prod
);

    localparam int CNT_W = $clog2(MOD_WIDTH + 1);

    logic [MOD_WIDTH-1:0] r_a, n_a;
    logic [MOD_WIDTH-1:0] r_b, n_b;
    logic [MOD_WIDTH-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_done, n_done;
    logic [MOD_WIDTH+1:0] w_t;
    logic [MOD_WIDTH+1:0] w_m1;
    logic [MOD_WIDTH+1:0] w_m2;
    logic [MOD_WIDTH+1:0] w_red;

    assign w_m1 = {2'b00, i_mod};
    assign w_m2 = {1'b0, i_mod, 1'b0};
    assign w_t  = {1'b0, r_acc, 1'b0}
                + (r_a[MOD_WIDTH-1] ? {2'b00, r_b} : '0);

    always_comb begin
        if (w_t >= w_m2) begin
            w_red = w_t - w_m2;
        end else if (w_t >= w_m1) begin
            w_red = w_t - w_m1;
        end else begin
            w_red = w_t;
        end
    end

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_a   = i_a;
            n_b   = i_b;
            n_acc = '0;
            n_cnt = CNT_W'(MOD_WIDTH);
        end else if (r_cnt != '0) begin
            n_a    = r_a << 1;
            n_acc  = w_red[MOD_WIDTH-1:0];
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hw/rtl/mexp_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks on the command handshake and result strobe.
// ----------------------------------------------------------------------------
module mexp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("accepted word did not raise busy");

    a_strobe_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy && $past(busy))
        else $error("result strobe without a word in flight");

    a_free_after_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("block still busy after result strobe");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
